@@ hw/rtl/decimal_float_to_text_top_defines.svh @@
// Assertion macros shared by the checker. Each expects clk and arst_n in scope.
`ifndef DECIMAL_FLOAT_TO_TEXT_TOP_DEFINES_SVH
`define DECIMAL_FLOAT_TO_TEXT_TOP_DEFINES_SVH

// Same-cycle implication.
`define DFT_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("DFT assertion failed");

// Next-cycle implication.
`define DFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("DFT assertion failed");

`endif

@@ hw/rtl/dft_pkg.sv @@
package dft_pkg;

	localparam int MAX_DIGITS_DEF = 17;
	localparam int SIG_W          = 57;
	localparam int EXP_W          = 10;
	localparam int BCD_DIGITS     = 18;
	localparam int BCD_W          = BCD_DIGITS * 4;
	localparam int BITS_PER_STEP  = 3;
	localparam int CONV_STEPS     = SIG_W / BITS_PER_STEP;
	localparam int MAX_CHARS      = 24;
	localparam int LEAD_W         = 12;
	localparam int Q_DEPTH        = 2;
	localparam int PTR_W          = $clog2(Q_DEPTH);

	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_DOT   = 7'h2E;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_E     = 7'h65;

	typedef enum logic [1:0] {
		CLS_FINITE = 2'd0,
		CLS_ZERO   = 2'd1,
		CLS_INF    = 2'd2,
		CLS_NAN    = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		MODE_SCI,
		MODE_FIXPOS,
		MODE_FIXNEG
	} mode_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_CONV,
		F_NORM,
		F_EXP,
		F_HUND,
		F_TENS,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SIGN,
		B_STR,
		B_LZ0,
		B_INT,
		B_DOT,
		B_ZEROS,
		B_FRAC,
		B_ZTAIL,
		B_E,
		B_EM,
		B_EH,
		B_ET,
		B_EU
	} back_state_t;

	// One classified value, ready for the formatter.
	typedef struct packed {
		cls_t              cls;
		logic              neg;
		logic [BCD_W-1:0]  dig;   // leading digit in the top nibble
		logic [4:0]        nd;    // digits to print
		mode_t             mode;
		logic [4:0]        icnt;  // integer places in fixed notation
		logic [1:0]        zcnt;  // zeros after the point for small values
		logic              lneg;
		logic [3:0]        eh;
		logic [3:0]        et;
		logic [3:0]        eu;
		logic              ge100;
		logic              ge10;
	} entry_t;

	function automatic logic [6:0] str_char(cls_t c, logic [2:0] idx);
		logic [6:0] ch;
		ch = CH_ZERO;
		case (c)
			CLS_NAN: begin
				case (idx)
					3'd0: ch = 7'h4E;
					3'd1: ch = 7'h61;
					default: ch = 7'h4E;
				endcase
			end
			CLS_INF: begin
				case (idx)
					3'd0: ch = 7'h49;
					3'd1: ch = 7'h6E;
					3'd2: ch = 7'h66;
					3'd3: ch = 7'h69;
					3'd4: ch = 7'h6E;
					3'd5: ch = 7'h69;
					3'd6: ch = 7'h74;
					default: ch = 7'h79;
				endcase
			end
			default: begin
				case (idx)
					3'd1: ch = CH_DOT;
					default: ch = CH_ZERO;
				endcase
			end
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] str_last(cls_t c);
		return (c == CLS_INF) ? 3'd7 : 3'd2;
	endfunction

endpackage

@@ hw/rtl/dft_in_if.sv @@
interface dft_in_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         value_class;
	logic                               negative;
	logic [dft_pkg::SIG_W-1:0]          significand;
	logic signed [dft_pkg::EXP_W-1:0]   dec_exponent;

	modport source (output valid, value_class, negative, significand, dec_exponent,
		input ready);
	modport sink (input valid, value_class, negative, significand, dec_exponent,
		output ready);
endinterface

@@ hw/rtl/dft_out_if.sv @@
interface dft_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink (input valid, char_code, last_char, output ready);
endinterface

@@ hw/rtl/dft_front.sv @@
module dft_front #(
	parameter int MAX_DIGITS = dft_pkg::MAX_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	dft_in_if.sink           in_ch,
	output dft_pkg::entry_t  wr_data,
	output logic             wr_en,
	input  logic             wr_full
);

	dft_pkg::front_state_t st_q, st_n;
	logic [dft_pkg::SIG_W-1:0]        sig_q;
	logic [dft_pkg::BCD_W-1:0]        bcd_q;
	logic signed [dft_pkg::EXP_W-1:0] exp_q;
	logic [4:0]                       step_q;
	logic [4:0]                       ndf_q;
	logic [9:0]                       mag_q;
	logic [6:0]                       hrem_q;
	dft_pkg::entry_t                  ent_q;

	logic                             accept;
	logic                             finite_nz;
	logic [dft_pkg::BCD_W-1:0]        conv_bcd;
	logic [dft_pkg::SIG_W-1:0]        conv_sig;
	logic [4:0]                       ndf_c;
	logic signed [dft_pkg::LEAD_W-1:0] lead_c;
	logic [3:0]                       h_c;
	logic [3:0]                       t_c;

	assign accept    = in_ch.valid && in_ch.ready;
	assign finite_nz = (in_ch.value_class == dft_pkg::CLS_FINITE) && (in_ch.significand != '0);
	assign in_ch.ready = (st_q == dft_pkg::F_IDLE);
	assign wr_data     = ent_q;

	// Shift-and-add binary to decimal, several bits per cycle.
	always_comb begin
		conv_bcd = bcd_q;
		conv_sig = sig_q;
		for (int b = 0; b < dft_pkg::BITS_PER_STEP; b++) begin
			for (int d = 0; d < dft_pkg::BCD_DIGITS; d++) begin
				if (conv_bcd[d*4 +: 4] >= 4'd5)
					conv_bcd[d*4 +: 4] = conv_bcd[d*4 +: 4] + 4'd3;
			end
			conv_bcd = {conv_bcd[dft_pkg::BCD_W-2:0], conv_sig[dft_pkg::SIG_W-1]};
			conv_sig = {conv_sig[dft_pkg::SIG_W-2:0], 1'b0};
		end
	end

	always_comb begin
		ndf_c = '0;
		for (int d = 0; d < dft_pkg::BCD_DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0)
				ndf_c = 5'(d + 1);
		end
	end

	assign lead_c = dft_pkg::LEAD_W'(exp_q) + $signed({7'd0, ndf_q}) - 12'sd1;

	always_comb begin
		h_c = '0;
		for (int k = 1; k < 10; k++) begin
			if (mag_q >= 10'(100 * k))
				h_c = 4'(k);
		end
		t_c = '0;
		for (int k = 1; k < 10; k++) begin
			if (hrem_q >= 7'(10 * k))
				t_c = 4'(k);
		end
	end

	always_comb begin
		st_n  = st_q;
		wr_en = 1'b0;
		case (st_q)
			dft_pkg::F_IDLE: begin
				if (accept)
					st_n = finite_nz ? dft_pkg::F_CONV : dft_pkg::F_PUSH;
			end
			dft_pkg::F_CONV: begin
				if (step_q == 5'(dft_pkg::CONV_STEPS - 1))
					st_n = dft_pkg::F_NORM;
			end
			dft_pkg::F_NORM: st_n = dft_pkg::F_EXP;
			dft_pkg::F_EXP:  st_n = dft_pkg::F_HUND;
			dft_pkg::F_HUND: st_n = dft_pkg::F_TENS;
			dft_pkg::F_TENS: st_n = dft_pkg::F_PUSH;
			dft_pkg::F_PUSH: begin
				wr_en = !wr_full;
				if (!wr_full)
					st_n = dft_pkg::F_IDLE;
			end
			default: st_n = dft_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= dft_pkg::F_IDLE;
		else
			st_q <= st_n;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			dft_pkg::F_IDLE: begin
				if (accept) begin
					sig_q      <= in_ch.significand;
					exp_q      <= in_ch.dec_exponent;
					bcd_q      <= '0;
					step_q     <= '0;
					ent_q.neg  <= in_ch.negative;
					if (in_ch.value_class == dft_pkg::CLS_FINITE && !finite_nz)
						ent_q.cls <= dft_pkg::CLS_ZERO;
					else
						ent_q.cls <= dft_pkg::cls_t'(in_ch.value_class);
				end
			end
			dft_pkg::F_CONV: begin
				bcd_q  <= conv_bcd;
				sig_q  <= conv_sig;
				step_q <= step_q + 5'd1;
			end
			dft_pkg::F_NORM: ndf_q <= ndf_c;
			dft_pkg::F_EXP: begin
				ent_q.dig  <= bcd_q << {5'(dft_pkg::BCD_DIGITS) - ndf_q, 2'b00};
				ent_q.nd   <= (ndf_q > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : ndf_q;
				ent_q.lneg <= lead_c < 0;
				mag_q      <= (lead_c < 0) ? 10'(-lead_c) : 10'(lead_c);
				ent_q.icnt <= 5'd1;
				ent_q.zcnt <= 2'(-lead_c - 12'sd1);
				if (lead_c <= -12'sd5 || lead_c >= 12'sd16) begin
					ent_q.mode <= dft_pkg::MODE_SCI;
				end else if (lead_c >= 0) begin
					ent_q.mode <= dft_pkg::MODE_FIXPOS;
					ent_q.icnt <= 5'(lead_c + 12'sd1);
				end else begin
					ent_q.mode <= dft_pkg::MODE_FIXNEG;
				end
			end
			dft_pkg::F_HUND: begin
				ent_q.eh    <= h_c;
				hrem_q      <= 7'(mag_q - 10'(h_c) * 10'd100);
				ent_q.ge100 <= mag_q >= 10'd100;
				ent_q.ge10  <= mag_q >= 10'd10;
			end
			dft_pkg::F_TENS: begin
				ent_q.et <= t_c;
				ent_q.eu <= 4'(hrem_q - 7'(t_c) * 7'd10);
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/dft_fifo.sv @@
module dft_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  dft_pkg::entry_t  wr_data,
	output logic             full,
	input  logic             rd_en,
	output dft_pkg::entry_t  rd_data,
	output logic             empty
);

	dft_pkg::entry_t               mem_q [dft_pkg::Q_DEPTH];
	logic [dft_pkg::PTR_W-1:0]     wp_q, rp_q;
	logic [dft_pkg::PTR_W:0]       cnt_q;

	assign full    = cnt_q == (dft_pkg::PTR_W+1)'(dft_pkg::Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= wp_q + 1'b1;
			if (rd_en)
				rp_q <= rp_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/dft_back.sv @@
module dft_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dft_pkg::entry_t  rd_data,
	input  logic             rd_empty,
	output logic             rd_en,
	dft_out_if.source        out_ch
);

	dft_pkg::back_state_t st_q, st_n, first;
	dft_pkg::entry_t      e_q;
	logic [dft_pkg::BCD_W-1:0] dig_q;
	logic [4:0]           rem_q;
	logic [4:0]           cnt_q, cnt_n;
	logic [4:0]           nout_q;
	logic                 ov_q;
	logic [6:0]           oc_q;
	logic                 ol_q;

	logic                 adv;
	logic [6:0]           ch;
	logic                 fin;
	logic                 take;
	logic                 last;
	dft_pkg::back_state_t after_e;
	logic [6:0]           dchar;

	assign out_ch.valid     = ov_q;
	assign out_ch.char_code = oc_q;
	assign out_ch.last_char = ol_q;

	assign adv   = (st_q != dft_pkg::B_IDLE) && (!ov_q || out_ch.ready);
	assign rd_en = (st_q == dft_pkg::B_IDLE) && !rd_empty;
	assign dchar = {3'b011, dig_q[dft_pkg::BCD_W-1 -: 4]};
	assign last  = fin || (nout_q == 5'(dft_pkg::MAX_CHARS - 1));

	function automatic dft_pkg::back_state_t body_start(dft_pkg::entry_t e);
		if (e.cls != dft_pkg::CLS_FINITE)
			return dft_pkg::B_STR;
		if (e.mode == dft_pkg::MODE_FIXNEG)
			return dft_pkg::B_LZ0;
		return dft_pkg::B_INT;
	endfunction

	function automatic logic [4:0] cnt_init(dft_pkg::back_state_t s, dft_pkg::entry_t e);
		case (s)
			dft_pkg::B_INT:   return e.icnt;
			dft_pkg::B_ZEROS: return {3'd0, e.zcnt};
			default:          return '0;
		endcase
	endfunction

	assign first = (rd_data.neg && rd_data.cls != dft_pkg::CLS_NAN) ?
		dft_pkg::B_SIGN : body_start(rd_data);

	assign after_e = e_q.ge100 ? dft_pkg::B_EH : (e_q.ge10 ? dft_pkg::B_ET : dft_pkg::B_EU);

	always_comb begin
		st_n = st_q;
		ch   = dft_pkg::CH_ZERO;
		fin  = 1'b0;
		take = 1'b0;
		case (st_q)
			dft_pkg::B_IDLE: begin
				if (!rd_empty)
					st_n = first;
			end
			dft_pkg::B_SIGN: begin
				ch   = dft_pkg::CH_MINUS;
				st_n = body_start(e_q);
			end
			dft_pkg::B_STR: begin
				ch  = dft_pkg::str_char(e_q.cls, cnt_q[2:0]);
				fin = cnt_q[2:0] == dft_pkg::str_last(e_q.cls);
			end
			dft_pkg::B_LZ0: st_n = dft_pkg::B_DOT;
			dft_pkg::B_INT: begin
				take = rem_q != '0;
				ch   = take ? dchar : dft_pkg::CH_ZERO;
				if (cnt_q == 5'd1) begin
					if (e_q.mode == dft_pkg::MODE_SCI)
						st_n = (rem_q > 5'd1) ? dft_pkg::B_DOT : dft_pkg::B_E;
					else
						st_n = dft_pkg::B_DOT;
				end
			end
			dft_pkg::B_DOT: begin
				ch = dft_pkg::CH_DOT;
				case (e_q.mode)
					dft_pkg::MODE_FIXPOS:
						st_n = (rem_q != '0) ? dft_pkg::B_FRAC : dft_pkg::B_ZTAIL;
					dft_pkg::MODE_FIXNEG:
						st_n = (e_q.zcnt != '0) ? dft_pkg::B_ZEROS : dft_pkg::B_FRAC;
					default:
						st_n = dft_pkg::B_FRAC;
				endcase
			end
			dft_pkg::B_ZEROS: begin
				if (cnt_q == 5'd1)
					st_n = dft_pkg::B_FRAC;
			end
			dft_pkg::B_FRAC: begin
				take = 1'b1;
				ch   = dchar;
				if (rem_q == 5'd1) begin
					if (e_q.mode == dft_pkg::MODE_SCI)
						st_n = dft_pkg::B_E;
					else
						fin = 1'b1;
				end
			end
			dft_pkg::B_ZTAIL: fin = 1'b1;
			dft_pkg::B_E: begin
				ch   = dft_pkg::CH_E;
				st_n = e_q.lneg ? dft_pkg::B_EM : after_e;
			end
			dft_pkg::B_EM: begin
				ch   = dft_pkg::CH_MINUS;
				st_n = after_e;
			end
			dft_pkg::B_EH: begin
				ch   = {3'b011, e_q.eh};
				st_n = dft_pkg::B_ET;
			end
			dft_pkg::B_ET: begin
				ch   = {3'b011, e_q.et};
				st_n = dft_pkg::B_EU;
			end
			dft_pkg::B_EU: begin
				ch  = {3'b011, e_q.eu};
				fin = 1'b1;
			end
			default: st_n = dft_pkg::B_IDLE;
		endcase
		// A text that hits the character limit ends early.
		if (st_q != dft_pkg::B_IDLE && last)
			st_n = dft_pkg::B_IDLE;
		if (st_q == dft_pkg::B_IDLE)
			cnt_n = cnt_init(st_n, rd_data);
		else if (st_n != st_q)
			cnt_n = cnt_init(st_n, e_q);
		else if (st_q == dft_pkg::B_STR)
			cnt_n = cnt_q + 5'd1;
		else
			cnt_n = cnt_q - 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dft_pkg::B_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (rd_en || adv)
				st_q <= st_n;
			if (adv)
				ov_q <= 1'b1;
			else if (out_ch.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			e_q    <= rd_data;
			dig_q  <= rd_data.dig;
			rem_q  <= rd_data.nd;
			cnt_q  <= cnt_n;
			nout_q <= '0;
		end else if (adv) begin
			cnt_q  <= cnt_n;
			nout_q <= nout_q + 5'd1;
			oc_q   <= ch;
			ol_q   <= last;
			if (take) begin
				dig_q <= {dig_q[dft_pkg::BCD_W-5:0], 4'd0};
				rem_q <= rem_q - 5'd1;
			end
		end
	end

endmodule

@@ hw/rtl/decimal_float_to_text_top.sv @@
// Prints a short decimal float as ASCII, one character per output beat, the
// final beat flagged by last_char. A front unit takes one value, converts its
// significand to decimal three bits per cycle (finite non-zero values only)
// and classifies it, then hands it through a two-entry queue to a formatter
// that sends one character per cycle while the output is ready, at most 24
// per value. The front takes a new value only once it has pushed the last one
// into the queue; the queue lets conversion of the next value overlap
// printing of the current one.
module decimal_float_to_text_top #(
	parameter int MAX_DIGITS = dft_pkg::MAX_DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dft_in_if.sink    in_ch,
	dft_out_if.source out_ch
);

	dft_pkg::entry_t wr_data, rd_data;
	logic            wr_en, full, rd_en, empty;

	dft_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.wr_data (wr_data),
		.wr_en   (wr_en),
		.wr_full (full)
	);

	dft_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.empty   (empty)
	);

	dft_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_data  (rd_data),
		.rd_empty (empty),
		.rd_en    (rd_en),
		.out_ch   (out_ch)
	);

endmodule

@@ hw/rtl/dft_checker.sv @@
`include "decimal_float_to_text_top_defines.svh"

module dft_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] char_code,
	input logic       last_char
);

	// A stalled beat keeps its character.
	`DFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(last_char))
	// The front works on one value at a time.
	`DFT_ASSERT_NEXT(a_in_single, in_valid && in_ready, !in_ready)
	// Every character is a sign, point, digit or letter.
	`DFT_ASSERT_IMPLY(a_char_range, out_valid, char_code >= 7'h2D && char_code <= 7'h79)

endmodule

bind decimal_float_to_text_top dft_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.char_code (out_ch.char_code),
	.last_char (out_ch.last_char)
);

@@ test/decimal_float_to_text_checker.sv @@
module decimal_float_to_text_checker (
	input  logic clk,
	input  logic arst_n,
	dft_in_if    in_ch,
	dft_out_if   out_ch,
	output int   fail_count,
	output int   chars_pending
);
	import dft_pkg::*;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} text_char_t;

	text_char_t char_queue[$];
	byte        text_buf[$];

	assign chars_pending = char_queue.size();

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	function automatic void push_char(byte c);
		text_buf.push_back(c);
	endfunction

	// Builds the printed text of one value and queues its characters.
	function automatic void predict_text(logic [1:0] vclass, logic neg,
		logic [SIG_W-1:0] sig_in, logic signed [EXP_W-1:0] exp_in);
		logic [63:0] sig;
		int          exp10, nd, lead, mag, i;
		byte         digs[$];
		text_buf.delete();
		sig = sig_in;
		exp10 = exp_in;
		if (cls_t'(vclass) == CLS_NAN) begin
			push_char("N"); push_char("a"); push_char("N");
		end else begin
			if (neg)
				push_char("-");
			if (cls_t'(vclass) == CLS_INF) begin
				push_char("I"); push_char("n"); push_char("f"); push_char("i");
				push_char("n"); push_char("i"); push_char("t"); push_char("y");
			end else if (cls_t'(vclass) == CLS_ZERO || sig == 0) begin
				push_char("0"); push_char("."); push_char("0");
			end else begin
				while (sig != 0) begin
					digs.push_front(byte'(sig % 10) + 8'd48);
					sig = sig / 10;
				end
				nd = digs.size();
				if (nd > MAX_DIGITS_DEF) begin
					exp10 += nd - MAX_DIGITS_DEF;
					nd = MAX_DIGITS_DEF;
				end
				lead = exp10 + nd - 1;
				if (lead <= -5 || lead >= 16) begin
					push_char(digs[0]);
					if (nd > 1) begin
						push_char(".");
						for (i = 1; i < nd; i++)
							push_char(digs[i]);
					end
					push_char("e");
					if (lead < 0) begin
						push_char("-");
						mag = -lead;
					end else begin
						mag = lead;
					end
					if (mag >= 100)
						push_char(byte'((mag / 100) % 10) + 8'd48);
					if (mag >= 10)
						push_char(byte'((mag / 10) % 10) + 8'd48);
					push_char(byte'(mag % 10) + 8'd48);
				end else if (lead >= 0) begin
					for (i = 0; i <= lead; i++)
						push_char(i < nd ? digs[i] : "0");
					push_char(".");
					if (lead + 1 < nd) begin
						for (i = lead + 1; i < nd; i++)
							push_char(digs[i]);
					end else begin
						push_char("0");
					end
				end else begin
					push_char("0"); push_char(".");
					for (i = 0; i < -lead - 1; i++)
						push_char("0");
					for (i = 0; i < nd; i++)
						push_char(digs[i]);
				end
			end
		end
		if (text_buf.size() > MAX_CHARS)
			text_buf = text_buf[0:MAX_CHARS-1];
		foreach (text_buf[i])
			char_queue.push_back('{text_buf[i][6:0], i == text_buf.size() - 1});
	endfunction

	initial fail_count = 0;

	always @(posedge clk) begin
		text_char_t want_char;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (char_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected char %h", out_ch.char_code));
				end else begin
					want_char = char_queue.pop_front();
					if (out_ch.char_code !== want_char.code)
						report_mismatch($sformatf("char_code %h, want %h",
							out_ch.char_code, want_char.code));
					if (out_ch.last_char !== want_char.last)
						report_mismatch($sformatf("last_char %b, want %b on %h",
							out_ch.last_char, want_char.last, want_char.code));
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_text(in_ch.value_class, in_ch.negative, in_ch.significand,
					in_ch.dec_exponent);
		end
	end
endmodule

@@ test/decimal_float_to_text_top_tb.sv @@
module decimal_float_to_text_top_tb;
	import dft_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   chars_pending;

	dft_in_if  in_ch ();
	dft_out_if out_ch ();

	decimal_float_to_text_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	decimal_float_to_text_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.fail_count    (fail_count),
		.chars_pending (chars_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.value_class = '0;
		in_ch.negative = 1'b0;
		in_ch.significand = '0;
		in_ch.dec_exponent = '0;
		out_ch.ready = 1'b0;
	end

	// Receiver stall pattern: free runs, each followed by a stalled run that may be empty.
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(0, 3) == 0 ? $urandom_range(30, 120) : $urandom_range(1, 8);
			repeat (run) @(posedge clk) out_ch.ready <= 1'b1;
			run = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
			repeat (run) @(posedge clk) out_ch.ready <= 1'b0;
		end
	end

	int burst_left = 0;

	// Valid stays high across a burst; it drops only for a gap.
	task automatic send_value(logic [1:0] vclass, logic neg, logic [SIG_W-1:0] sig,
		logic signed [EXP_W-1:0] exp10);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.value_class <= vclass;
		in_ch.negative <= neg;
		in_ch.significand <= sig;
		in_ch.dec_exponent <= exp10;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic logic [SIG_W-1:0] rand_sig(int nd);
		logic [63:0] v;
		v = $urandom_range(1, 9);
		for (int i = 1; i < nd; i++)
			v = v * 10 + $urandom_range(0, 9);
		return v[SIG_W-1:0];
	endfunction

	initial begin
		logic [SIG_W-1:0] sig;
		int               nd, r;
		logic signed [EXP_W-1:0] e;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_value(CLS_NAN, 1'b1, '1, '1);
		send_value(CLS_NAN, 1'b0, '0, '0);
		send_value(CLS_INF, 1'b0, '0, '0);
		send_value(CLS_INF, 1'b1, 57'd5, 10'sd3);
		send_value(CLS_ZERO, 1'b0, 57'd7, 10'sd2);
		send_value(CLS_ZERO, 1'b1, '0, '0);
		send_value(CLS_FINITE, 1'b1, '0, 10'sd5);
		send_value(CLS_FINITE, 1'b0, 57'd99999999999999999, 10'sd308);
		send_value(CLS_FINITE, 1'b1, 57'd1, -10'sd324);
		send_value(CLS_FINITE, 1'b0, '1, 10'sd0);
		send_value(CLS_FINITE, 1'b0, 57'd123456789012345678, -10'sd5);
		send_value(CLS_FINITE, 1'b0, 57'd5, 10'sd20);
		send_value(CLS_FINITE, 1'b0, 57'd12300, 10'sd0);
		send_value(CLS_FINITE, 1'b0, 57'd1, 10'sd15);
		send_value(CLS_FINITE, 1'b0, 57'd1, 10'sd16);
		send_value(CLS_FINITE, 1'b0, 57'd1, -10'sd4);
		send_value(CLS_FINITE, 1'b0, 57'd1, -10'sd5);
		send_value(CLS_FINITE, 1'b0, 57'd12345, -10'sd3);
		send_value(CLS_FINITE, 1'b1, 57'd12345, -10'sd8);
		send_value(CLS_FINITE, 1'b0, 57'd7, 10'sd511);
		send_value(CLS_FINITE, 1'b0, 57'd7, -10'sd512);
		send_value(CLS_FINITE, 1'b0, 57'd42, 10'sd0);
		for (int k = 0; k < 350; k++) begin
			r = $urandom_range(0, 19);
			nd = $urandom_range(0, 3) == 0 ? $urandom_range(1, 18) : $urandom_range(1, 6);
			sig = rand_sig(nd);
			if (r == 0)
				sig = SIG_W'({$urandom, $urandom});
			if (r < 12)
				e = $signed(10'($urandom_range(0, 40))) - 10'sd20 - 10'(nd);
			else
				e = 10'($urandom);
			send_value(r == 19 ? CLS_NAN : r == 18 ? CLS_INF : r == 17 ? CLS_ZERO : CLS_FINITE,
				1'($urandom), sig, e);
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (chars_pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && chars_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
